// ===== rtl/hcle_pkg.sv =====
// hcle_pkg: shared types and constants for the hash comment line extractor
// holds payload structs, controller/datapath command and status structs
// no dependencies
package hcle_pkg;

    // fixed field widths
    localparam int CHAR_W     = 8;
    localparam int OUT_NUM_W  = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CODE_COUNT = 5;

    localparam logic [OUT_NUM_W-1:0] OUT_NUM_MAX = 20'hFFFFF;

    // character constants
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ZERO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ONE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_TWO     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_THREE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_FOUR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_LINES = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ONLY    = 3'd6;

    // input request payload
    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              end_of_text;
    } in_item_t;

    // output request payload
    typedef struct packed {
        logic [CHAR_W-1:0]    char_out;
        logic                 line_tag_valid;
        logic [OUT_NUM_W-1:0] line_number;
        logic                 truncated;
        logic                 last_of_run;
    } out_item_t;

    // source of an emitted byte
    typedef enum logic [1:0] {
        OSRC_REPLAY,
        OSRC_COPY,
        OSRC_NL
    } out_src_t;

    // controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     append;
        logic     set_ovf;
        logic     end_line;
        logic     reset_text;
        logic     rp_start;
        logic     rp_lim_nl;
        logic     rp_read;
        logic     out_load;
        out_src_t out_src;
        logic     out_tag;
        logic     out_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic eot;
        logic is_nl;
        logic is_quote;
        logic is_bslash;
        logic is_hash;
        logic code_match;
        logic code0_zero;
        logic buf_full;
        logic rp_first;
        logic rp_last;
        logic rp_done;
        logic lim_zero;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/hcle_ctrl.sv =====
// hcle_ctrl: scan mode tracking and sequencing of replay and copy
// depends on hcle_pkg (cmd_t, status_t, out_src_t)
module hcle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_stall,
    input  hcle_pkg::status_t sts,
    output hcle_pkg::cmd_t    cmd
);
    import hcle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RLOAD,
        S_RREAD,
        S_REMIT,
        S_COPY,
        S_NL
    } state_t;

    typedef enum logic [2:0] {
        M_NORMAL,
        M_STRING,
        M_ESCAPE,
        M_HASH,
        M_COPY
    } mode_t;

    typedef enum logic [1:0] {
        POST_COPY,
        POST_NL,
        POST_EOT
    } post_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    post_t  post_reg, post_next;
    logic   do_normal;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        post_next  = post_reg;
        do_normal  = 1'b0;
        cmd        = '0;
        cmd.out_src = OSRC_COPY;

        case (state_reg)
            S_IDLE:
            begin
                if (text_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_IDLE;
                if (sts.eot)
                begin
                    if (mode_reg == M_HASH && sts.code0_zero)
                    begin
                        post_next  = POST_EOT;
                        state_next = S_RLOAD;
                    end
                    else
                    begin
                        cmd.reset_text = 1'b1;
                        mode_next      = M_NORMAL;
                    end
                end
                else
                begin
                    case (mode_reg)
                        M_STRING:
                        begin
                            if (sts.is_nl)
                            begin
                                cmd.end_line = 1'b1;
                                mode_next    = M_NORMAL;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                if (sts.is_quote)
                                    mode_next = M_NORMAL;
                            end
                        end
                        M_ESCAPE:
                        begin
                            if (sts.is_hash)
                            begin
                                cmd.append = 1'b1;
                                mode_next  = M_NORMAL;
                            end
                            else
                                do_normal = 1'b1;
                        end
                        M_HASH:
                        begin
                            if (!sts.code_match)
                                do_normal = 1'b1;
                            else if (sts.is_nl)
                            begin
                                // prefix replay capped one short of the buffer
                                cmd.set_ovf = sts.buf_full;
                                post_next   = POST_NL;
                                state_next  = S_RLOAD;
                            end
                            else
                            begin
                                cmd.append = 1'b1;
                                post_next  = POST_COPY;
                                state_next = S_RLOAD;
                            end
                        end
                        M_COPY:
                            state_next = S_COPY;
                        default:
                            do_normal = 1'b1;
                    endcase
                end

                // ordinary scanning of one byte
                if (do_normal)
                begin
                    if (sts.is_nl)
                    begin
                        cmd.end_line = 1'b1;
                        mode_next    = M_NORMAL;
                    end
                    else
                    begin
                        cmd.append = 1'b1;
                        if (sts.is_quote)
                            mode_next = M_STRING;
                        else if (sts.is_bslash)
                            mode_next = M_ESCAPE;
                        else if (sts.is_hash)
                            mode_next = M_HASH;
                        else
                            mode_next = M_NORMAL;
                    end
                end
            end

            S_RLOAD:
            begin
                cmd.rp_start  = 1'b1;
                cmd.rp_lim_nl = (post_reg == POST_NL);
                state_next    = S_RREAD;
            end

            S_RREAD:
            begin
                if (sts.rp_done)
                begin
                    case (post_reg)
                        POST_NL:
                            state_next = S_NL;
                        POST_EOT:
                        begin
                            cmd.reset_text = 1'b1;
                            mode_next      = M_NORMAL;
                            state_next     = S_IDLE;
                        end
                        default:
                        begin
                            mode_next  = M_COPY;
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    cmd.rp_read = 1'b1;
                    state_next  = S_REMIT;
                end
            end

            S_REMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OSRC_REPLAY;
                    cmd.out_tag  = sts.rp_first;
                    cmd.out_last = sts.rp_last && (post_reg != POST_NL);
                    state_next   = S_RREAD;
                end
            end

            S_NL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OSRC_NL;
                    cmd.out_tag  = sts.lim_zero;
                    cmd.out_last = 1'b1;
                    cmd.end_line = 1'b1;
                    mode_next    = M_NORMAL;
                    state_next   = S_IDLE;
                end
            end

            S_COPY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OSRC_COPY;
                    cmd.out_last = 1'b1;
                    if (sts.is_nl)
                    begin
                        cmd.end_line = 1'b1;
                        mode_next    = M_NORMAL;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= M_NORMAL;
            post_reg  <= POST_COPY;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            post_reg  <= post_next;
        end
    end

    assign text_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/hcle_dp.sv =====
// hcle_dp: line buffer, line counter, config registers and output register
// depends on hcle_pkg (payload structs, cmd_t, status_t, constants)
module hcle_dp #(
    parameter int LINE_MAX        = 64,
    parameter int LINE_COUNT_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hcle_pkg::in_item_t                  text_data,
    input  logic                                cfg_we,
    input  logic [hcle_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hcle_pkg::CHAR_W-1:0]         cfg_data,
    output logic                                doc_valid,
    input  logic                                doc_stall,
    output hcle_pkg::out_item_t                 doc_data,
    input  hcle_pkg::cmd_t                      cmd,
    output hcle_pkg::status_t                   sts
);
    import hcle_pkg::*;

    localparam int AW     = $clog2(LINE_MAX);
    localparam int FILL_W = $clog2(LINE_MAX + 1);
    localparam int LCB    = LINE_COUNT_BITS;

    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(LINE_MAX);
    localparam logic [FILL_W-1:0] FILL_CAPN = FILL_W'(LINE_MAX - 1);

    // configuration
    logic [CHAR_W-1:0] code_reg [CODE_COUNT];
    logic              number_lines_reg;
    logic              text_only_reg;

    // line state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [LCB-1:0]    count_reg, count_next;
    logic              ovf_reg, ovf_next;

    // input byte and replay pointer
    logic [CHAR_W-1:0] in_byte_reg;
    logic              eot_reg;
    logic [FILL_W-1:0] rp_idx_reg;
    logic [FILL_W-1:0] rp_lim_reg;
    logic [CHAR_W-1:0] rd_byte_reg;

    // line buffer
    logic [CHAR_W-1:0] line_mem [LINE_MAX];

    // output register
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic              buf_full;
    logic              match_any;
    logic              out_free;
    logic [LCB-1:0]    cnt_inc;
    logic [32:0]       ln_wide;
    logic [OUT_NUM_W-1:0] line_num;
    logic [CHAR_W-1:0] out_char;

    assign buf_full = (fill_reg == FILL_MAX);
    assign out_free = !out_valid_reg || !doc_stall;

    // configuration writes and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CODE_COUNT; i++)
                code_reg[i] <= '0;
            number_lines_reg <= 1'b0;
            text_only_reg    <= 1'b0;
            fill_reg         <= '0;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CODE_ZERO:    code_reg[0] <= cfg_data;
                    CFG_CODE_ONE:     code_reg[1] <= cfg_data;
                    CFG_CODE_TWO:     code_reg[2] <= cfg_data;
                    CFG_CODE_THREE:   code_reg[3] <= cfg_data;
                    CFG_CODE_FOUR:    code_reg[4] <= cfg_data;
                    CFG_NUMBER_LINES: number_lines_reg <= cfg_data[0];
                    CFG_TEXT_ONLY:    text_only_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            fill_reg  <= fill_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!doc_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // fill, line count and overflow updates
    always_comb
    begin
        fill_next  = fill_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.append)
        begin
            if (!buf_full)
                fill_next = FILL_W'(fill_reg + 1'b1);
            else
                ovf_next = 1'b1;
        end
        if (cmd.set_ovf)
            ovf_next = 1'b1;
        if (cmd.end_line)
        begin
            if (count_reg != '1)
                count_next = LCB'(count_reg + 1'b1);
            fill_next = '0;
            ovf_next  = 1'b0;
        end
        if (cmd.reset_text)
        begin
            fill_next  = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // input capture and replay pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_byte_reg <= text_data.char_in;
            eot_reg     <= text_data.end_of_text;
        end
        if (cmd.rp_start)
        begin
            rp_idx_reg <= '0;
            rp_lim_reg <= (cmd.rp_lim_nl && buf_full) ? FILL_CAPN : fill_reg;
        end
        else if (cmd.out_load && cmd.out_src == OSRC_REPLAY)
            rp_idx_reg <= FILL_W'(rp_idx_reg + 1'b1);
    end

    // line buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.append && !buf_full)
            line_mem[fill_reg[AW-1:0]] <= in_byte_reg;
        if (cmd.rp_read)
            rd_byte_reg <= line_mem[rp_idx_reg[AW-1:0]];
    end

    // code byte match
    always_comb
    begin
        match_any = (code_reg[0] == '0);
        for (int i = 0; i < CODE_COUNT; i++)
            if (code_reg[i] == in_byte_reg)
                match_any = 1'b1;
    end

    // current line number, saturating at counter and output width
    always_comb
    begin
        cnt_inc  = (count_reg == '1) ? count_reg : LCB'(count_reg + 1'b1);
        ln_wide  = 33'(cnt_inc);
        line_num = (ln_wide > 33'(OUT_NUM_MAX)) ? OUT_NUM_MAX : ln_wide[OUT_NUM_W-1:0];
    end

    // emitted byte select
    always_comb
    begin
        case (cmd.out_src)
            OSRC_REPLAY:
                out_char = (text_only_reg && rd_byte_reg != CH_TAB) ? CH_SPACE : rd_byte_reg;
            OSRC_NL:
                out_char = CH_NL;
            default:
                out_char = in_byte_reg;
        endcase
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.char_out       <= out_char;
            out_data_reg.line_tag_valid <= cmd.out_tag && number_lines_reg;
            out_data_reg.line_number    <= (cmd.out_tag && number_lines_reg) ? line_num : '0;
            out_data_reg.truncated      <= ovf_reg;
            out_data_reg.last_of_run    <= cmd.out_last;
        end
    end

    assign doc_valid = out_valid_reg;
    assign doc_data  = out_data_reg;

    // status to controller
    always_comb
    begin
        sts.eot        = eot_reg;
        sts.is_nl      = (in_byte_reg == CH_NL);
        sts.is_quote   = (in_byte_reg == CH_QUOTE);
        sts.is_bslash  = (in_byte_reg == CH_BSLASH);
        sts.is_hash    = (in_byte_reg == CH_HASH);
        sts.code_match = match_any;
        sts.code0_zero = (code_reg[0] == '0);
        sts.buf_full   = buf_full;
        sts.rp_first   = (rp_idx_reg == '0);
        sts.rp_last    = ((FILL_W + 1)'(rp_idx_reg) + 1'b1) == (FILL_W + 1)'(rp_lim_reg);
        sts.rp_done    = (rp_idx_reg == rp_lim_reg);
        sts.lim_zero   = (rp_lim_reg == '0);
        sts.out_free   = out_free;
    end

endmodule

// ===== rtl/hash_comment_line_extractor.sv =====
// A byte is taken into the input register and decided in the next cycle; a copied comment
// byte then goes into the output register once that register is free. A new byte is only
// taken once the last one is through. A comment match replays the buffered line byte by
// byte (one read port, registered read) after a setup step, plus a newline for a newline code byte.
// Reset (rst_n, async, active low) clears scan state, counters and config registers to 0;
// the line buffer is not cleared and needs no clearing pass.
module hash_comment_line_extractor #(
    parameter int LINE_MAX        = 64,
    parameter int LINE_COUNT_BITS = 20
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           text_valid,
    output logic                           text_stall,
    input  hcle_pkg::in_item_t             text_data,
    output logic                           doc_valid,
    input  logic                           doc_stall,
    output hcle_pkg::out_item_t            doc_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hcle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcle_pkg::CHAR_W-1:0]    cfg_data
);
    import hcle_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // controller
    hcle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath
    hcle_dp #(
        .LINE_MAX        (LINE_MAX),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_data (text_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .doc_valid (doc_valid),
        .doc_stall (doc_stall),
        .doc_data  (doc_data),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTH
    // an accepted byte is always worked on before the next one is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && !text_stall) |=> text_stall)
        else $error("input taken twice in a row");

    // the controller never overwrites a result that is still waiting
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while occupied");

    // untagged bytes carry no line number
    a_untagged_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (doc_valid && !doc_data.line_tag_valid) |-> (doc_data.line_number == '0))
        else $error("line number on untagged byte");
`endif

endmodule
